>>> rtl/core/hclp_pkg.sv
// ----------------------------------------------------------------------------
// hclp_pkg
// Shared types, character codes and hex helpers for the command line parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hclp_pkg;

  // characters of the command grammar
  localparam logic [7:0] CHAR_R     = 8'h52;
  localparam logic [7:0] CHAR_W     = 8'h57;
  localparam logic [7:0] CHAR_B     = 8'h42;
  localparam logic [7:0] CHAR_S     = 8'h53;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;

  // hex digit ranges, bounds exclusive
  localparam logic [7:0] DEC_LO     = 8'd47;
  localparam logic [7:0] DEC_HI     = 8'd58;
  localparam logic [7:0] ALPHA_LO   = 8'd64;
  localparam logic [7:0] ALPHA_HI   = 8'd71;
  localparam logic [7:0] DEC_BASE   = 8'd48;
  localparam logic [7:0] ALPHA_BASE = 8'd55;

  // highest legal first address character ('7')
  localparam logic [7:0] ADDR_FIRST_MAX = 8'd55;

  localparam int unsigned ADDR_W  = 15;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned EVENT_W = 3;
  localparam int unsigned DCNT_W  = 3;
  localparam logic [DCNT_W-1:0] DIGITS_PAIR = 3'd2;
  localparam logic [DCNT_W-1:0] DIGITS_ADDR = 3'd4;

  // result event codes
  typedef enum logic [EVENT_W-1:0] {
    EV_NONE   = 3'd0,
    EV_WB     = 3'd1,
    EV_WSDATA = 3'd2,
    EV_RB     = 3'd3,
    EV_RS     = 3'd4,
    EV_ERR    = 3'd5,
    EV_WSEND  = 3'd6
  } event_e;

  // parser states, one-hot
  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_R    = 11'b000_0000_0010,
    ST_W    = 11'b000_0000_0100,
    ST_RB_A = 11'b000_0000_1000,
    ST_RS_A = 11'b000_0001_0000,
    ST_WB_A = 11'b000_0010_0000,
    ST_WS_A = 11'b000_0100_0000,
    ST_RS_C = 11'b000_1000_0000,
    ST_WB_V = 11'b001_0000_0000,
    ST_WS_C = 11'b010_0000_0000,
    ST_WS_D = 11'b100_0000_0000
  } state_e;

  // one result item
  typedef struct packed {
    event_e              event_res;
    logic [ADDR_W-1:0]   mem_address;
    logic [BYTE_W-1:0]   data_value;
    logic [BYTE_W-1:0]   repeat_count;
  } res_t;

  // ascii hex character to nibble, anything else reads as zero
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] diff;
    diff = 8'd0;
    if (c > DEC_LO && c < DEC_HI) begin
      diff = c - DEC_BASE;
    end else if (c > ALPHA_LO && c < ALPHA_HI) begin
      diff = c - ALPHA_BASE;
    end
    return diff[3:0];
  endfunction

  // two characters to one byte, first one is the high nibble
  function automatic logic [7:0] hex_pair(input logic [7:0] hi, input logic [7:0] lo);
    return {hex_nibble(hi), hex_nibble(lo)};
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/hclp_in_stage.sv
// ----------------------------------------------------------------------------
// hclp_in_stage
// Input register that holds one received character for the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module hclp_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       take_i,
  output logic            valid_o,
  output logic [7:0]      byte_o
);
  import hclp_pkg::*;

  logic       valid_q;
  logic [7:0] byte_q;

  // free when empty or when the held item moves on this cycle
  assign in_ready_o = !valid_q || take_i;

  // occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // character payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= rx_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

>>> rtl/core/hclp_parser.sv
// ----------------------------------------------------------------------------
// hclp_parser
// Command state machine with digit buffer and held address, value, count.
// ----------------------------------------------------------------------------
`default_nettype none

module hclp_parser (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  output hclp_pkg::res_t  res_o
);
  import hclp_pkg::*;

  state_e             state_q, state_d;
  logic [7:0]         buf0_q, buf0_d;
  logic [7:0]         buf1_q, buf1_d;
  logic [DCNT_W-1:0]  dcnt_q, dcnt_d;
  logic [7:0]         ah_q, ah_d;
  logic [7:0]         al_q, al_d;
  logic [7:0]         val_q, val_d;
  logic [7:0]         rcnt_q, rcnt_d;
  event_e             ev;
  logic [7:0]         addr_term;
  state_e             addr_next;
  event_e             addr_ev;
  logic [7:0]         pair_term;

  // terminators and follow-up states per field
  always_comb begin
    addr_term = CHAR_COMMA;
    addr_next = ST_IDLE;
    addr_ev   = EV_NONE;
    pair_term = CHAR_NL;
    case (state_q)
      ST_RB_A: begin
        addr_term = CHAR_NL;
        addr_next = ST_IDLE;
        addr_ev   = EV_RB;
      end
      ST_RS_A: addr_next = ST_RS_C;
      ST_WB_A: addr_next = ST_WB_V;
      ST_WS_A: addr_next = ST_WS_C;
      ST_WS_C: pair_term = CHAR_COMMA;
      default: ;
    endcase
  end

  // next state and held values for one character
  always_comb begin
    state_d = state_q;
    buf0_d  = buf0_q;
    buf1_d  = buf1_q;
    dcnt_d  = dcnt_q;
    ah_d    = ah_q;
    al_d    = al_q;
    val_d   = val_q;
    rcnt_d  = rcnt_q;
    ev      = EV_NONE;
    case (state_q)
      ST_IDLE: begin
        if (byte_i == CHAR_R) begin
          state_d = ST_R;
        end else if (byte_i == CHAR_W) begin
          state_d = ST_W;
        end
      end
      ST_R: begin
        if (byte_i == CHAR_B) begin
          state_d = ST_RB_A;
        end else if (byte_i == CHAR_S) begin
          state_d = ST_RS_A;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_W: begin
        if (byte_i == CHAR_B) begin
          state_d = ST_WB_A;
        end else if (byte_i == CHAR_S) begin
          state_d = ST_WS_A;
        end else begin
          state_d = ST_IDLE;
        end
      end
      // four address digits, the first pair is the high byte
      ST_RB_A, ST_RS_A, ST_WB_A, ST_WS_A: begin
        if (byte_i == addr_term) begin
          al_d    = hex_pair(buf0_q, buf1_q);
          state_d = addr_next;
          dcnt_d  = '0;
          ev      = addr_ev;
        end else if (dcnt_q < DIGITS_ADDR) begin
          if (dcnt_q[0]) begin
            buf1_d = byte_i;
          end else begin
            buf0_d = byte_i;
          end
          dcnt_d = dcnt_q + 1'b1;
          if (dcnt_q < DIGITS_PAIR) begin
            if (buf0_d > ADDR_FIRST_MAX) begin
              state_d = ST_IDLE;
              dcnt_d  = '0;
              ev      = EV_ERR;
            end else if (dcnt_d == DIGITS_PAIR) begin
              ah_d = hex_pair(buf0_d, buf1_d);
            end
          end
        end else begin
          state_d = ST_IDLE;
          dcnt_d  = '0;
          ev      = EV_ERR;
        end
      end
      // two-digit count or value field
      ST_RS_C, ST_WB_V, ST_WS_C: begin
        if (byte_i == pair_term) begin
          dcnt_d = '0;
          if (state_q == ST_RS_C) begin
            rcnt_d  = hex_pair(buf0_q, buf1_q);
            state_d = ST_IDLE;
            ev      = EV_RS;
          end else if (state_q == ST_WB_V) begin
            val_d   = hex_pair(buf0_q, buf1_q);
            state_d = ST_IDLE;
            ev      = EV_WB;
          end else begin
            rcnt_d  = hex_pair(buf0_q, buf1_q);
            state_d = ST_WS_D;
          end
        end else if (dcnt_q < DIGITS_PAIR) begin
          if (dcnt_q[0]) begin
            buf1_d = byte_i;
          end else begin
            buf0_d = byte_i;
          end
          dcnt_d = dcnt_q + 1'b1;
        end else begin
          state_d = ST_IDLE;
          dcnt_d  = '0;
          ev      = EV_ERR;
        end
      end
      // burst data, one event per completed pair
      ST_WS_D: begin
        if (byte_i == CHAR_NL) begin
          state_d = ST_IDLE;
          dcnt_d  = '0;
          ev      = EV_WSEND;
        end else if (dcnt_q < DIGITS_PAIR) begin
          if (dcnt_q[0]) begin
            buf1_d = byte_i;
          end else begin
            buf0_d = byte_i;
          end
          dcnt_d = dcnt_q + 1'b1;
          if (dcnt_d == DIGITS_PAIR) begin
            val_d  = hex_pair(buf0_d, buf1_d);
            dcnt_d = '0;
            ev     = EV_WSDATA;
          end
        end else begin
          state_d = ST_IDLE;
          dcnt_d  = '0;
          ev      = EV_ERR;
        end
      end
      default: ;
    endcase
  end

  // parser state, advanced once per character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      buf0_q  <= '0;
      buf1_q  <= '0;
      dcnt_q  <= '0;
      ah_q    <= '0;
      al_q    <= '0;
      val_q   <= '0;
      rcnt_q  <= '0;
    end else if (step_i) begin
      state_q <= state_d;
      buf0_q  <= buf0_d;
      buf1_q  <= buf1_d;
      dcnt_q  <= dcnt_d;
      ah_q    <= ah_d;
      al_q    <= al_d;
      val_q   <= val_d;
      rcnt_q  <= rcnt_d;
    end
  end

  // result carries the held fields after this character
  always_comb begin
    res_o.event_res    = ev;
    res_o.mem_address  = {ah_d[6:0], al_d};
    res_o.data_value   = val_d;
    res_o.repeat_count = rcnt_d;
  end

endmodule

`default_nettype wire

>>> rtl/core/hclp_out_stage.sv
// ----------------------------------------------------------------------------
// hclp_out_stage
// Result register toward the receiver of parse events.
// ----------------------------------------------------------------------------
`default_nettype none

module hclp_out_stage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            load_i,
  input  wire hclp_pkg::res_t  res_i,
  output logic                 space_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output hclp_pkg::res_t       res_o
);
  import hclp_pkg::*;

  logic valid_q;
  res_t res_q;

  // room when empty or when the held result is taken now
  assign space_o = !valid_q || out_ready_i;

  // occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= load_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (space_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

>>> rtl/core/hex_command_line_parser_top.sv
// ----------------------------------------------------------------------------
// hex_command_line_parser_top
// Parser for RB, RS, WB and WS memory commands typed as hex text.
// ----------------------------------------------------------------------------
// Input channel: one received ASCII character per item (rx_byte_i), with
// in_valid_i / in_ready_o. Output channel: one result item per character,
// with out_valid_o / out_ready_i, carrying an event code and the currently
// held address, data value and repeat count.
// An accepted character is held in the input register; its result is
// loaded into the result register when that register has room.
// Throughput: one character per cycle while the receiver does not stall;
// the state machine update and the hex conversion sit between the input
// register and the result register.
// When the receiver stalls, the result register holds, the input register
// fills, and in_ready_o drops only once both are occupied; a character is
// taken in the same cycle the stalled result is accepted.
// Reset: parser returns to idle, digit buffer, address, value and count
// clear to zero, and both registers are empty.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_command_line_parser_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [7:0]                    rx_byte_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [hclp_pkg::EVENT_W-1:0]       event_res_o,
  output logic [hclp_pkg::ADDR_W-1:0]        mem_address_o,
  output logic [hclp_pkg::BYTE_W-1:0]        data_value_o,
  output logic [hclp_pkg::BYTE_W-1:0]        repeat_count_o
);
  import hclp_pkg::*;

  logic       byte_v;
  logic [7:0] byte_q;
  logic       space;
  logic       advance;
  res_t       res_next;
  res_t       res_out;

  // a character moves on when the result register has room
  assign advance = byte_v && space;

  hclp_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .take_i     (advance),
    .valid_o    (byte_v),
    .byte_o     (byte_q)
  );

  hclp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (byte_q),
    .res_o  (res_next)
  );

  hclp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_i       (res_next),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  // result fields to ports
  assign event_res_o    = res_out.event_res;
  assign mem_address_o  = res_out.mem_address;
  assign data_value_o   = res_out.data_value;
  assign repeat_count_o = res_out.repeat_count;

`ifndef ASSERT_OFF
  // every parsed character leaves a result behind
  a_step_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("parsed character left no result");

  // an accepted character is held for the parser
  a_accept_fills_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> byte_v)
    else $error("accepted character not held");

  // input only blocks when both registers are full and the receiver stalls
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (byte_v && out_valid_o && !out_ready_i))
    else $error("input blocked without a full pipeline");
`endif

endmodule

`default_nettype wire
